[sv/lsa_pkg.sv]
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared constants and types for the LRU slot allocator: table size, field
// widths, command codes and the layouts of a slot entry and of a result item.
// ----------------------------------------------------------------------------
package lsa_pkg;

   // Table size and derived widths.
   localparam int NUM_SLOTS = 16;
   localparam int IDX_W     = $clog2(NUM_SLOTS);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   // Fixed field widths.
   localparam int TAG_W   = 32;
   localparam int AGE_W   = 32;
   localparam int CMD_W   = 3;
   localparam int LIMIT_W = 5;

   // Reset value of the capacity register.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOCK   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TOUCH  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd4;

   // One slot as kept in the slot memory.
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             locked;
      logic [AGE_W-1:0] age;
   } slot_entry_type;

   // One result item.
   typedef struct packed {
      logic             ok;
      logic [IDX_W-1:0] granted_slot;
      logic             freed_valid;
      logic [TAG_W-1:0] freed_tag;
      logic [CNT_W-1:0] free_count;
      logic             last;
   } rsp_type;

endpackage

[sv/lru_slot_allocator.sv]
// ----------------------------------------------------------------------------
// lru_slot_allocator
// Slot table with least-recently-used replacement and per-slot locking. All
// slot state sits in one synchronous memory; the controller reads, modifies
// and writes it back, scanning it one slot per cycle for eviction and flush.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high until
// the command is finished. Results appear on the rsp_ ports for one cycle each,
// marked by rsp_valid, and cannot be held off by the receiver. Allocate into a
// free slot, allocate on an empty table of capacity zero, an unknown command,
// and lock, unlock or touch on an unallocated slot are answered in the decode
// state; lock, unlock and touch on a valid slot read the entry, then write it
// back. Allocate on a full table scans the n allocated slots through the
// memory's single read port, whether it evicts a slot or is refused because
// every slot is locked. Flush streams its n tags one per cycle, and an empty
// flush gives a single result from the decode state. Results are registered.
// The capacity register may be written only while busy is low; the slot
// memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module lru_slot_allocator (
   input  logic                          clock,
   input  logic                          reset,

   // Command channel.
   input  logic                          start,
   output logic                          busy,
   input  logic [lsa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [lsa_pkg::TAG_W-1:0]     req_user_tag,
   input  logic [lsa_pkg::IDX_W-1:0]     req_slot_index,

   // Result channel.
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic [lsa_pkg::IDX_W-1:0]     rsp_granted_slot,
   output logic                          rsp_freed_valid,
   output logic [lsa_pkg::TAG_W-1:0]     rsp_freed_tag,
   output logic [lsa_pkg::CNT_W-1:0]     rsp_free_count,
   output logic                          rsp_last,

   // Capacity register write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lsa_pkg::LIMIT_W-1:0]   csr_data
);
   import lsa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RMW,
      ST_SCAN,
      ST_EVICT,
      ST_FLUSH
   } state_type;

   state_type            state_ff;
   logic [CMD_W-1:0]     cmd_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [LIMIT_W-1:0]   slot_limit_ff;
   logic [AGE_W-1:0]     age_counter_ff;
   logic [CNT_W-1:0]     used_count_ff;

   // Scan bookkeeping: issued read count, pending read and its slot.
   logic [CNT_W-1:0]     scan_n_ff;
   logic [CNT_W-1:0]     iss_ff;
   logic                 pend_ff;
   logic [CNT_W-1:0]     pend_idx_ff;

   // Eviction candidate.
   logic                 found_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [AGE_W-1:0]     best_age_ff;
   logic [TAG_W-1:0]     best_tag_ff;

   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   // Slot memory.
   slot_entry_type       slot_mem [NUM_SLOTS];
   slot_entry_type       mem_rd_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   slot_entry_type       wr_data;

   logic [CNT_W-1:0]     cap;
   logic                 has_room;
   logic                 scan_last;
   logic                 cand_better;
   slot_entry_type       fresh_entry;

   // Free slots left for a given capacity and fill level.
   function automatic logic [CNT_W-1:0] free_after(input logic [CNT_W-1:0] c,
                                                   input logic [CNT_W-1:0] u);
      free_after = (c > u) ? (c - u) : '0;
   endfunction

   // Builds one result item.
   function automatic rsp_type make_rsp(input logic             ok,
                                        input logic [IDX_W-1:0] slot,
                                        input logic             fv,
                                        input logic [TAG_W-1:0] ftag,
                                        input logic [CNT_W-1:0] fcnt,
                                        input logic             lst);
      rsp_type r;
      r.ok           = ok;
      r.granted_slot = slot;
      r.freed_valid  = fv;
      r.freed_tag    = ftag;
      r.free_count   = fcnt;
      r.last         = lst;
      make_rsp = r;
   endfunction

   // Capacity is the register value saturated to the table size.
   always_comb begin
      if (int'(slot_limit_ff) > NUM_SLOTS) begin
         cap = CNT_W'(NUM_SLOTS);
      end else begin
         cap = CNT_W'(slot_limit_ff);
      end
   end

   assign has_room  = (used_count_ff < cap);
   assign scan_last = pend_ff && (pend_idx_ff == (scan_n_ff - CNT_W'(1)));

   // An unlocked slot beats the candidate when it is strictly older.
   assign cand_better = !mem_rd_ff.locked && (!found_ff || (best_age_ff > mem_rd_ff.age));

   // Entry written by a grant.
   always_comb begin
      fresh_entry.tag    = tag_ff;
      fresh_entry.locked = 1'b0;
      fresh_entry.age    = age_counter_ff;
   end

   // Read address: the addressed slot while decoding, else the scan pointer.
   assign rd_addr = (state_ff == ST_EXEC) ? idx_ff : iss_ff[IDX_W-1:0];

   // Write port control.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = fresh_entry;
      case (state_ff)
         ST_EXEC: begin
            wr_en   = (cmd_ff == CMD_ALLOC) && has_room;
            wr_addr = used_count_ff[IDX_W-1:0];
         end
         ST_RMW: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = mem_rd_ff;
            if (cmd_ff == CMD_LOCK) begin
               wr_data.locked = 1'b1;
            end else if (cmd_ff == CMD_UNLOCK) begin
               wr_data.locked = 1'b0;
            end else begin
               wr_data.age = age_counter_ff;
            end
         end
         ST_EVICT: begin
            wr_en = found_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Slot memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   // Slot memory read port, registered.
   always_ff @(posedge clock) begin
      mem_rd_ff <= slot_mem[rd_addr];
   end

   // Capacity register; the user must write it only while the block is idle, which the block itself does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         slot_limit_ff <= csr_data;
      end
   end

   // Controller and registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         age_counter_ff <= '0;
         used_count_ff  <= '0;
         pend_ff        <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff   <= req_cmd;
                  tag_ff   <= req_user_tag;
                  idx_ff   <= req_slot_index;
                  state_ff <= ST_EXEC;
               end
            end

            ST_EXEC: begin
               iss_ff   <= '0;
               pend_ff  <= 1'b0;
               found_ff <= 1'b0;
               state_ff <= ST_IDLE;
               case (cmd_ff)
                  CMD_ALLOC: begin
                     if (has_room) begin
                        // Take the next unused slot.
                        used_count_ff  <= used_count_ff + CNT_W'(1);
                        age_counter_ff <= age_counter_ff + AGE_W'(1);
                        rsp_ff <= make_rsp(1'b1, used_count_ff[IDX_W-1:0], 1'b0, '0,
                                           free_after(cap, used_count_ff + CNT_W'(1)),
                                           1'b1);
                        rsp_valid_ff <= 1'b1;
                     end else if (used_count_ff == '0) begin
                        // No slots at all: refused.
                        rsp_ff <= make_rsp(1'b0, '0, 1'b0, '0,
                                           free_after(cap, used_count_ff), 1'b1);
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        scan_n_ff <= used_count_ff;
                        state_ff  <= ST_SCAN;
                     end
                  end
                  CMD_LOCK, CMD_UNLOCK, CMD_TOUCH: begin
                     if ({1'b0, idx_ff} >= (IDX_W + 1)'(used_count_ff)) begin
                        rsp_ff <= make_rsp(1'b0, '0, 1'b0, '0,
                                           free_after(cap, used_count_ff), 1'b1);
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        state_ff <= ST_RMW;
                     end
                  end
                  CMD_FLUSH: begin
                     used_count_ff <= '0;
                     if (used_count_ff == '0) begin
                        rsp_ff <= make_rsp(1'b1, '0, 1'b0, '0, cap, 1'b1);
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        scan_n_ff <= used_count_ff;
                        state_ff  <= ST_FLUSH;
                     end
                  end
                  default: begin
                     rsp_ff <= make_rsp(1'b0, '0, 1'b0, '0,
                                        free_after(cap, used_count_ff), 1'b1);
                     rsp_valid_ff <= 1'b1;
                  end
               endcase
            end

            ST_RMW: begin
               // The write port stores the modified entry this cycle.
               if (cmd_ff == CMD_TOUCH) begin
                  age_counter_ff <= age_counter_ff + AGE_W'(1);
               end
               rsp_ff <= make_rsp(1'b1, '0, 1'b0, '0,
                                  free_after(cap, used_count_ff), 1'b1);
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end

            ST_SCAN: begin
               // Issue one read a cycle and compare the slot returned.
               if (iss_ff < scan_n_ff) begin
                  iss_ff      <= iss_ff + CNT_W'(1);
                  pend_idx_ff <= iss_ff;
                  pend_ff     <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff && cand_better) begin
                  found_ff    <= 1'b1;
                  best_idx_ff <= pend_idx_ff[IDX_W-1:0];
                  best_age_ff <= mem_rd_ff.age;
                  best_tag_ff <= mem_rd_ff.tag;
               end
               if (scan_last) begin
                  state_ff <= ST_EVICT;
               end
            end

            ST_EVICT: begin
               // The write port replaces the oldest unlocked slot when there is one.
               if (found_ff) begin
                  age_counter_ff <= age_counter_ff + AGE_W'(1);
                  rsp_ff <= make_rsp(1'b1, best_idx_ff, 1'b1, best_tag_ff,
                                     free_after(cap, used_count_ff), 1'b1);
               end else begin
                  rsp_ff <= make_rsp(1'b0, '0, 1'b0, '0,
                                     free_after(cap, used_count_ff), 1'b1);
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end

            ST_FLUSH: begin
               // Stream each allocated tag in slot order; once every read has been
               // issued, the pending flag drops by itself.
               if (iss_ff < scan_n_ff) begin
                  iss_ff      <= iss_ff + CNT_W'(1);
                  pend_idx_ff <= iss_ff;
                  pend_ff     <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff) begin
                  rsp_ff <= make_rsp(1'b1, '0, 1'b1, mem_rd_ff.tag, cap, scan_last);
                  rsp_valid_ff <= 1'b1;
               end
               if (scan_last) begin
                  state_ff <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Port drivers.
   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ff.ok;
   assign rsp_granted_slot = rsp_ff.granted_slot;
   assign rsp_freed_valid  = rsp_ff.freed_valid;
   assign rsp_freed_tag    = rsp_ff.freed_tag;
   assign rsp_free_count   = rsp_ff.free_count;
   assign rsp_last         = rsp_ff.last;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU slot allocator. A shadow copy of the slot
// table predicts every result of each command it sends: fill, eviction,
// refusal, lock, unlock, touch and flush. The bench then compares the results
// on the rsp_ ports field by field, in order. It runs through several
// capacity settings, written between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import lsa_pkg::*;

   // Command codes that the block answers as unknown.
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_FLUSH + 3'd1;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

   // One command item with the idle cycles that come before it.
   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [TAG_W-1:0] tag;
      logic [IDX_W-1:0] slot;
      int               gap;
   } slot_op_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [TAG_W-1:0]    req_user_tag = '0;
   logic [IDX_W-1:0]    req_slot_index = '0;
   logic                rsp_valid;
   logic                rsp_ok;
   logic [IDX_W-1:0]    rsp_granted_slot;
   logic                rsp_freed_valid;
   logic [TAG_W-1:0]    rsp_freed_tag;
   logic [CNT_W-1:0]    rsp_free_count;
   logic                rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_data = '0;

   // Items waiting to be sent and results waiting to arrive.
   slot_op_type         op_backlog[$];
   rsp_type             awaited_rsps[$];

   // Shadow copy of the slot table.
   logic [TAG_W-1:0]    tbl_tag[NUM_SLOTS] = '{default: '0};
   logic                tbl_locked[NUM_SLOTS] = '{default: 1'b0};
   logic [AGE_W-1:0]    tbl_age[NUM_SLOTS] = '{default: '0};
   logic [AGE_W-1:0]    stamp_ctr = '0;
   int                  fill_count = 0;
   logic [LIMIT_W-1:0]  cap_limit = LIMIT_RESET;

   // Driver state and pacing of the stimulus.
   slot_op_type         cur_op = '{cmd: '0, tag: '0, slot: '0, gap: 0};
   bit                  have_item = 1'b0;
   int                  wait_cnt = 0;
   int                  burst_left = 0;
   bit                  no_idle = 1'b0;
   bit                  failed = 1'b0;

   lru_slot_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_user_tag     (req_user_tag),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_ok           (rsp_ok),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_freed_valid  (rsp_freed_valid),
      .rsp_freed_tag    (rsp_freed_tag),
      .rsp_free_count   (rsp_free_count),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Capacity of the table, saturated to the number of slots.
   function automatic int table_capacity();
      return (cap_limit > NUM_SLOTS) ? NUM_SLOTS : int'(cap_limit);
   endfunction

   // Unused slots left, never below zero.
   function automatic logic [CNT_W-1:0] unused_slots();
      int cap;
      cap = table_capacity();
      return (cap > fill_count) ? CNT_W'(cap - fill_count) : '0;
   endfunction

   // Applies one command to the shadow table and queues the results it causes.
   task automatic predict_slot_op(input slot_op_type op);
      rsp_type r;
      int      pick;
      int      n;
      bit      found;
      r = '0;
      r.last = 1'b1;
      pick = 0;
      found = 1'b0;
      case (op.cmd)
         CMD_ALLOC: begin
            // A full table evicts the oldest unlocked slot; lowest index wins ties.
            if (fill_count >= table_capacity()) begin
               for (int i = 0; i < fill_count; i++) begin
                  if (!tbl_locked[i] && (!found || tbl_age[pick] > tbl_age[i])) begin
                     pick = i;
                     found = 1'b1;
                  end
               end
               if (found) begin
                  r.freed_valid = 1'b1;
                  r.freed_tag = tbl_tag[pick];
               end
            end else begin
               pick = fill_count;
               fill_count++;
               found = 1'b1;
            end
            if (found) begin
               tbl_tag[pick] = op.tag;
               tbl_locked[pick] = 1'b0;
               tbl_age[pick] = stamp_ctr;
               stamp_ctr++;
               r.ok = 1'b1;
               r.granted_slot = IDX_W'(pick);
            end
            r.free_count = unused_slots();
            awaited_rsps.push_back(r);
         end
         CMD_LOCK, CMD_UNLOCK, CMD_TOUCH: begin
            // Commands on a slot that is not filled are refused.
            if (op.slot < fill_count) begin
               r.ok = 1'b1;
               if (op.cmd == CMD_LOCK) begin
                  tbl_locked[op.slot] = 1'b1;
               end else if (op.cmd == CMD_UNLOCK) begin
                  tbl_locked[op.slot] = 1'b0;
               end else begin
                  tbl_age[op.slot] = stamp_ctr;
                  stamp_ctr++;
               end
            end
            r.free_count = unused_slots();
            awaited_rsps.push_back(r);
         end
         CMD_FLUSH: begin
            // The table empties first, so every flush result shows it empty.
            n = fill_count;
            fill_count = 0;
            r.ok = 1'b1;
            r.free_count = unused_slots();
            if (n == 0) begin
               awaited_rsps.push_back(r);
            end else begin
               r.freed_valid = 1'b1;
               for (int i = 0; i < n; i++) begin
                  r.freed_tag = tbl_tag[i];
                  r.last = (i == n - 1);
                  awaited_rsps.push_back(r);
               end
            end
         end
         default: begin
            r.free_count = unused_slots();
            awaited_rsps.push_back(r);
         end
      endcase
   endtask

   // Queues one item; idle gaps come in runs, some of them with no idling at all.
   task automatic queue_op(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                           input logic [IDX_W-1:0] slot);
      slot_op_type op;
      if (burst_left == 0) begin
         no_idle = ($urandom_range(0, 3) == 0);
         burst_left = $urandom_range(5, 30);
      end
      burst_left--;
      op.cmd = cmd;
      op.tag = tag;
      op.slot = slot;
      op.gap = no_idle ? 0 : $urandom_range(0, 19);
      op_backlog.push_back(op);
   endtask

   // Random items, mostly on slots below the capacity, with some flushes and unknown codes.
   task automatic queue_random_ops(input int count, input int cap);
      int               sel;
      int               top;
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] slot;
      top = (cap > NUM_SLOTS) ? NUM_SLOTS : cap;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         if (top == 0 || $urandom_range(0, 4) == 0) begin
            slot = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
         end else begin
            slot = IDX_W'($urandom_range(0, top - 1));
         end
         if (sel < 45) begin
            cmd = CMD_ALLOC;
         end else if (sel < 60) begin
            cmd = CMD_LOCK;
         end else if (sel < 75) begin
            cmd = CMD_UNLOCK;
         end else if (sel < 90) begin
            cmd = CMD_TOUCH;
         end else if (sel < 95) begin
            cmd = CMD_FLUSH;
         end else begin
            cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
         end
         queue_op(cmd, $urandom, slot);
      end
   endtask

   // Waits until nothing is left to send and every result has arrived.
   task automatic wait_idle();
      while (op_backlog.size() != 0 || have_item || awaited_rsps.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Writes the capacity register and updates the shadow copy at the handshake.
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      cap_limit = value;
   endtask

   // Compares one field of a result and reports a difference.
   task automatic check_field(input string name, input logic [TAG_W-1:0] exp_val,
                              input logic [TAG_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, got_val);
         failed = 1'b1;
      end
   endtask

   // Driver: holds start high until the item is taken, then paces the next one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_slot_op(cur_op);
            have_item = 1'b0;
         end
         if (!have_item && op_backlog.size() != 0) begin
            cur_op = op_backlog.pop_front();
            have_item = 1'b1;
            wait_cnt = cur_op.gap;
         end
         if (have_item && wait_cnt == 0) begin
            start <= 1'b1;
         end else begin
            start <= 1'b0;
            if (have_item) begin
               wait_cnt--;
            end
         end
         req_cmd <= cur_op.cmd;
         req_user_tag <= cur_op.tag;
         req_slot_index <= cur_op.slot;
      end
   end

   // Monitor: every strobed result is matched against the oldest prediction.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (awaited_rsps.size() == 0) begin
            $error("result with no item outstanding: freed_tag %0h", rsp_freed_tag);
            failed = 1'b1;
         end else begin
            exp_rsp = awaited_rsps.pop_front();
            check_field("ok", TAG_W'(exp_rsp.ok), TAG_W'(rsp_ok));
            check_field("granted_slot", TAG_W'(exp_rsp.granted_slot),
                        TAG_W'(rsp_granted_slot));
            check_field("freed_valid", TAG_W'(exp_rsp.freed_valid), TAG_W'(rsp_freed_valid));
            check_field("freed_tag", exp_rsp.freed_tag, rsp_freed_tag);
            check_field("free_count", TAG_W'(exp_rsp.free_count), TAG_W'(rsp_free_count));
            check_field("last", TAG_W'(exp_rsp.last), TAG_W'(rsp_last));
         end
      end
   end

   // Stimulus: a directed pass on a three-slot table, then random phases.
   initial begin
      logic [LIMIT_W-1:0] limits[9];
      limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd12, 5'd16};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_limit(5'd3);
      // Empty flush, refused commands on unfilled slots and unknown codes.
      queue_op(CMD_FLUSH, '0, '0);
      queue_op(CMD_LOCK, '0, 4'd0);
      queue_op(CMD_TOUCH, '0, 4'd15);
      queue_op(CMD_UNLOCK, '0, 4'd8);
      queue_op(CMD_UNUSED_LO, 32'hFFFF_FFFF, 4'd15);
      queue_op(CMD_UNUSED_LO + 3'd1, '0, '0);
      queue_op(CMD_UNUSED_HI, '0, '0);
      // Fill the table, then evict the oldest slot.
      queue_op(CMD_ALLOC, 32'h0000_0000, '0);
      queue_op(CMD_ALLOC, 32'hFFFF_FFFF, '0);
      queue_op(CMD_ALLOC, 32'h5A5A_A5A5, '0);
      queue_op(CMD_ALLOC, 32'h1234_5678, '0);
      // A touch and a lock steer the next eviction away from slots 1 and 2.
      queue_op(CMD_TOUCH, '0, 4'd1);
      queue_op(CMD_LOCK, '0, 4'd2);
      queue_op(CMD_ALLOC, 32'hDEAD_BEEF, '0);
      // With every slot locked the grant is refused.
      queue_op(CMD_LOCK, '0, 4'd0);
      queue_op(CMD_LOCK, '0, 4'd1);
      queue_op(CMD_ALLOC, 32'h8000_0001, '0);
      queue_op(CMD_UNLOCK, '0, 4'd1);
      queue_op(CMD_ALLOC, 32'h7FFF_FFFE, '0);
      queue_op(CMD_TOUCH, '0, 4'd3);
      queue_op(CMD_FLUSH, '0, '0);
      wait_idle();

      // Random phases; the table carries over, so lowered limits find it overfull.
      foreach (limits[p]) begin
         write_limit(limits[p]);
         queue_random_ops(40, int'(limits[p]));
         wait_idle();
      end

      // Let any stray result show up before the verdict.
      repeat (40) @(posedge clock);
      if (awaited_rsps.size() != 0) begin
         $error("%0d expected results never arrived", awaited_rsps.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("lru_slot_allocator: match");
      end else begin
         $display("lru_slot_allocator: mismatch");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("lru_slot_allocator: mismatch");
      $finish;
   end

endmodule

[files.f]
sv/lsa_pkg.sv
sv/lru_slot_allocator.sv
tb/sv/tb_top.sv
